### design/fan_curve_duty_controller_core_assert.svh
// Assertion helpers shared by the fan curve controller.
`ifndef FAN_CURVE_DUTY_CONTROLLER_CORE_ASSERT_SVH
`define FAN_CURVE_DUTY_CONTROLLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/fcdc_pkg.sv
package fcdc_pkg;

	// Default width of the period timer.
	localparam int TIME_BITS_DEF = 32;

	// Field widths.
	localparam int TEMP_W   = 12;
	localparam int PWM_W    = 8;
	localparam int MS_W     = 27;
	localparam int DELTA_W  = 10;
	localparam int NOW_W    = 32;
	localparam int CFG_IDX_W = 3;

	// Curve arithmetic widths: the product of a 13-bit difference and a
	// 9-bit span has a magnitude below 2^20.
	localparam int PROD_W = 22;
	localparam int NUM_W  = 20;
	localparam int DEN_W  = 12;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_LOW    = 3'd0,
		REG_TEMP_HIGH   = 3'd1,
		REG_MIN_PWM     = 3'd2,
		REG_MAX_PWM     = 3'd3,
		REG_DUTY_MODE   = 3'd4,
		REG_PERIOD_MS   = 3'd5,
		REG_ON_MS       = 3'd6,
		REG_FORCE_DELTA = 3'd7
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_START,
		ST_WAIT,
		ST_FIN
	} seq_state_t;

	// Divider status toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### design/fcdc_div.sv
module fcdc_div
	import fcdc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0] quotient,
	output div_stat_t        stat
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] div_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] diff;
	logic             ge;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff    = {1'b0, shifted} - (DEN_W+2)'(div_q);
		ge      = !diff[DEN_W+1];
	end

	// Step counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

### design/fan_curve_duty_controller_core.sv
// Fan curve duty controller. Each input beat (temperature, target, millisecond
// timestamp) yields one output beat (PWM duty, forced-cooling flag). An item
// goes from acceptance to the output register through the curve multiply, the
// load of the divider, the steps of the restoring divider until it flags done,
// and the clamp and duty window in the finish state. in_stall stays high while
// an item is in work; a finished item waits in the finish state while an
// earlier result is still held by out_stall, and the next input beat is taken
// as soon as the result is in the output register.
// Configuration writes take effect at once.
`include "fan_curve_duty_controller_core_assert.svh"

module fan_curve_duty_controller_core
	import fcdc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [MS_W-1:0]             cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [TEMP_W-1:0]    temp_tenths,
	input  logic signed [TEMP_W-1:0]    target_tenths,
	input  logic [NOW_W-1:0]            now_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [PWM_W-1:0]            pwm_duty,
	output logic                        cooling_forced
);

	localparam int NW = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;
	localparam int CW = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

	// Configuration registers.
	logic signed [TEMP_W-1:0] lo_q;
	logic signed [TEMP_W-1:0] hi_q;
	logic [PWM_W-1:0]         min_q;
	logic [PWM_W-1:0]         max_q;
	logic                     duty_q;
	logic [MS_W-1:0]          period_q;
	logic [MS_W-1:0]          on_q;
	logic [DELTA_W-1:0]       delta_q;

	// Item registers and state.
	seq_state_t               state_q, state_d;
	logic signed [TEMP_W-1:0] t_q;
	logic signed [TEMP_W-1:0] tgt_q;
	logic [NOW_W-1:0]         now_q;
	logic [NUM_W-1:0]         mag_q;
	logic                     neg_q;
	logic [TIME_BITS-1:0]     pstart_q;
	logic                     out_valid_q;
	logic [PWM_W-1:0]         pwm_q;
	logic                     forced_q;

	// Sequencer controls.
	logic in_take;
	logic div_start;
	logic fin_go;

	// Divider connection.
	logic [NUM_W-1:0] quo;
	div_stat_t        div_stat;
	logic [DEN_W-1:0] den;

	// Curve datapath.
	logic signed [TEMP_W:0]   tdiff;
	logic signed [PWM_W:0]    span;
	logic signed [PROD_W-1:0] prod;
	logic signed [NUM_W:0]    qs;
	logic signed [PROD_W-1:0] pmin_c;
	logic signed [PROD_W-1:0] pmax_c;
	logic signed [PROD_W-1:0] curve;
	logic signed [PROD_W-1:0] raw;
	logic signed [PROD_W-1:0] clamped;
	logic signed [TEMP_W+1:0] tgt_sum;
	logic                     forced;

	// Timer datapath.
	logic [NW-1:0]        now_wide;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] start_eff;
	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS-1:0] elapsed_eff;
	logic                 roll;
	logic                 window_off;
	logic [PWM_W-1:0]     pwm_final;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q     <= TEMP_W'(370);
			hi_q     <= TEMP_W'(390);
			min_q    <= PWM_W'(60);
			max_q    <= PWM_W'(255);
			duty_q   <= 1'b1;
			period_q <= MS_W'(300000);
			on_q     <= MS_W'(60000);
			delta_q  <= DELTA_W'(5);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TEMP_LOW:    lo_q     <= $signed(cfg_data[TEMP_W-1:0]);
				REG_TEMP_HIGH:   hi_q     <= $signed(cfg_data[TEMP_W-1:0]);
				REG_MIN_PWM:     min_q    <= cfg_data[PWM_W-1:0];
				REG_MAX_PWM:     max_q    <= cfg_data[PWM_W-1:0];
				REG_DUTY_MODE:   duty_q   <= cfg_data[0];
				REG_PERIOD_MS:   period_q <= cfg_data;
				REG_ON_MS:       on_q     <= cfg_data;
				REG_FORCE_DELTA: delta_q  <= cfg_data[DELTA_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer controls.
	always_comb begin
		state_d   = state_q;
		in_take   = 1'b0;
		div_start = 1'b0;
		fin_go    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_take = in_valid;
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_START;
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_stat.done) state_d = ST_FIN;
			end
			ST_FIN: begin
				fin_go = !(out_valid_q && out_stall);
				if (fin_go) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// Capture the input beat.
	always_ff @(posedge clk) begin
		if (in_take) begin
			t_q   <= temp_tenths;
			tgt_q <= target_tenths;
			now_q <= now_ms;
		end
	end

	// Curve numerator: (t - lo) * (max - min), kept as sign and magnitude.
	always_comb begin
		tdiff = (TEMP_W+1)'(t_q) - (TEMP_W+1)'(lo_q);
		span  = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
		prod  = PROD_W'(tdiff) * PROD_W'(span);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			neg_q <= prod[PROD_W-1];
			mag_q <= prod[PROD_W-1] ? NUM_W'(-prod) : NUM_W'(prod);
		end
	end

	// Band width; only meaningful when the band is not empty.
	assign den = DEN_W'((TEMP_W+1)'(hi_q) - (TEMP_W+1)'(lo_q));

	fcdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (den),
		.quotient (quo),
		.stat     (div_stat)
	);

	// Signed quotient, offset, empty band case and clamp.
	always_comb begin
		qs     = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		pmin_c = $signed({{(PROD_W-PWM_W){1'b0}}, min_q});
		pmax_c = $signed({{(PROD_W-PWM_W){1'b0}}, max_q});
		curve  = PROD_W'(qs) + pmin_c;
		if (hi_q <= lo_q) begin
			raw = (t_q >= hi_q) ? pmax_c : pmin_c;
		end else begin
			raw = curve;
		end
		priority if (raw < pmin_c) begin
			clamped = pmin_c;
		end else if (raw > pmax_c) begin
			clamped = pmax_c;
		end else begin
			clamped = raw;
		end
		tgt_sum = (TEMP_W+2)'(tgt_q) + $signed({4'd0, delta_q});
		forced  = (TEMP_W+2)'(t_q) >= tgt_sum;
	end

	// Period timer and on window.
	always_comb begin
		now_wide    = NW'(now_q);
		now_t       = now_wide[TIME_BITS-1:0];
		start_eff   = (pstart_q == '0) ? now_t : pstart_q;
		elapsed     = now_t - start_eff;
		roll        = CW'(elapsed) >= CW'(period_q);
		elapsed_eff = roll ? '0 : elapsed;
		window_off  = !(CW'(elapsed_eff) < CW'(on_q));
		pwm_final   = (duty_q && !forced && window_off) ? '0 : clamped[PWM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstart_q <= '0;
		end else if (fin_go && duty_q) begin
			pstart_q <= roll ? now_t : start_eff;
		end
	end

	// Output register; a new result may replace one taken in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			pwm_q    <= pwm_final;
			forced_q <= forced;
		end
	end

	assign out_valid      = out_valid_q;
	assign pwm_duty       = pwm_q;
	assign cooling_forced = forced_q;

	// Checks on the sequencer and the divider handshake.
	`FCDC_ASSERT_SAME(a_start_idle_div, clk, arst_n, div_start, !div_stat.busy, "divider restarted while busy")
	`FCDC_ASSERT_SAME(a_done_in_wait, clk, arst_n, div_stat.done, state_q == ST_WAIT, "divider done outside wait")
	`FCDC_ASSERT_NEXT(a_take_to_mul, clk, arst_n, in_valid && !in_stall, state_q == ST_MUL, "accepted beat did not start work")
	`FCDC_ASSERT_SAME(a_valid_from_fin, clk, arst_n, $rose(out_valid), $past(state_q == ST_FIN), "result appeared without finish")

endmodule
